FILE: hdl/assert_macros.svh
// Assertion macros shared by the encoder RTL.
// Needs a clock named clock and a synchronous reset named reset in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define CPWE_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define CPWE_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/cpwe_pkg.sv
// Package for the cassette pulse width encoder: codes, sizes and shared types.
// No dependencies; used by cpwe_pulse_fetch and cassette_pulse_width_encoder.
`timescale 1ns / 1ps

package cpwe_pkg;

   localparam int COUNT_BITS = 16;
   localparam int OP_W       = 3;
   localparam int VALUE_W    = 16;
   localparam int LEN_W      = 8;
   localparam int SEQ_LEN    = 18;
   localparam int POS_W      = 5;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int ONES_W     = 4;

   localparam logic [OP_W-1:0] OP_TICK = 3'd0;
   localparam logic [OP_W-1:0] OP_BYTE = 3'd1;
   localparam logic [OP_W-1:0] OP_GAP  = 3'd2;
   localparam logic [OP_W-1:0] OP_MARK = 3'd3;
   localparam logic [OP_W-1:0] OP_CSUM = 3'd4;

   localparam logic [2:0] REG_LONG_HIGH  = 3'd0;
   localparam logic [2:0] REG_LONG_LOW   = 3'd1;
   localparam logic [2:0] REG_SHORT_HIGH = 3'd2;
   localparam logic [2:0] REG_SHORT_LOW  = 3'd3;
   localparam logic [2:0] REG_POLARITY   = 3'd4;

   localparam logic [LEN_W-1:0] RESET_LONG_LEN  = 8'd21;
   localparam logic [LEN_W-1:0] RESET_SHORT_LEN = 8'd11;

   localparam logic [7:0] LEVEL_FIRST  = 8'h30;
   localparam logic [7:0] LEVEL_SECOND = 8'hd0;

   localparam logic [POS_W-1:0] BYTE_PULSES = 5'd9;
   localparam logic [POS_W-1:0] CSUM_PULSES = 5'd18;

   localparam logic [1:0] STAGE_LEAD  = 2'd0;
   localparam logic [1:0] STAGE_SHORT = 2'd1;
   localparam logic [1:0] STAGE_TAIL  = 2'd2;

   localparam logic [VALUE_W-1:0] TAIL_PULSES = 16'd2;

   typedef enum logic [2:0] {
      KIND_IDLE = 3'b001,
      KIND_SEQ  = 3'b010,
      KIND_RUN  = 3'b100
   } kind_type;

   typedef struct packed {
      logic               is_seq;
      logic [SEQ_LEN-1:0] seq;
      logic [POS_W-1:0]   len;
      logic [POS_W-1:0]   pos;
      logic [1:0]         stage;
      logic [VALUE_W-1:0] run_left;
      logic [VALUE_W-1:0] mark_n;
      logic               mark;
   } fetch_req_type;

   typedef struct packed {
      logic               found;
      logic               is_long;
      logic [POS_W-1:0]   pos;
      logic [1:0]         stage;
      logic [VALUE_W-1:0] run_left;
   } fetch_rsp_type;

   typedef struct packed {
      logic              sample_valid;
      logic [7:0]        sample;
      logic              busy_res;
      logic              accepted;
      logic [ONES_W-1:0] ones_count;
   } rsp_type;

endpackage

FILE: hdl/cpwe_pulse_fetch.sv
// Next-pulse finder: picks the next pulse that emits samples, skipping empty ones.
// Depends on cpwe_pkg.
`timescale 1ns / 1ps

module cpwe_pulse_fetch (
   input  cpwe_pkg::fetch_req_type fetch_req,
   input  logic                    long_ok,
   input  logic                    short_ok,
   output cpwe_pkg::fetch_rsp_type fetch_rsp
);

   logic [cpwe_pkg::SEQ_LEN-1:0] cand;
   logic [cpwe_pkg::POS_W-1:0]   first;
   logic                         lead_go;
   logic                         short_go;
   logic                         tail_go;
   logic [cpwe_pkg::VALUE_W-1:0] short_cnt;
   logic [cpwe_pkg::VALUE_W-1:0] tail_cnt;

   always_comb begin
      for (int j = 0; j < cpwe_pkg::SEQ_LEN; j++) begin
         cand[j] = (cpwe_pkg::POS_W'(j) >= fetch_req.pos) &&
                   (cpwe_pkg::POS_W'(j) < fetch_req.len) &&
                   (fetch_req.seq[j] ? long_ok : short_ok);
      end
      first = '0;
      for (int j = cpwe_pkg::SEQ_LEN - 1; j >= 0; j--) begin
         if (cand[j]) begin
            first = cpwe_pkg::POS_W'(j);
         end
      end
   end

   always_comb begin
      short_cnt = (fetch_req.stage == cpwe_pkg::STAGE_SHORT) ? fetch_req.run_left
                                                             : fetch_req.mark_n;
      tail_cnt  = (fetch_req.stage == cpwe_pkg::STAGE_TAIL) ? fetch_req.run_left
                                                            : cpwe_pkg::TAIL_PULSES;
      lead_go   = (fetch_req.stage == cpwe_pkg::STAGE_LEAD) &&
                  (fetch_req.run_left != '0) && long_ok;
      short_go  = ((fetch_req.stage == cpwe_pkg::STAGE_LEAD) ||
                   (fetch_req.stage == cpwe_pkg::STAGE_SHORT)) &&
                  (short_cnt != '0) && short_ok;
      tail_go   = fetch_req.mark && (tail_cnt != '0) && long_ok;

      fetch_rsp.found    = 1'b0;
      fetch_rsp.is_long  = 1'b0;
      fetch_rsp.pos      = fetch_req.pos;
      fetch_rsp.stage    = fetch_req.stage;
      fetch_rsp.run_left = fetch_req.run_left;

      if (fetch_req.is_seq) begin
         fetch_rsp.found   = |cand;
         fetch_rsp.is_long = fetch_req.seq[first];
         fetch_rsp.pos     = first + 5'd1;
      end else if (lead_go) begin
         fetch_rsp.found    = 1'b1;
         fetch_rsp.is_long  = 1'b1;
         fetch_rsp.stage    = cpwe_pkg::STAGE_LEAD;
         fetch_rsp.run_left = fetch_req.run_left - 16'd1;
      end else if (short_go) begin
         fetch_rsp.found    = 1'b1;
         fetch_rsp.is_long  = 1'b0;
         fetch_rsp.stage    = cpwe_pkg::STAGE_SHORT;
         fetch_rsp.run_left = short_cnt - 16'd1;
      end else if (tail_go) begin
         fetch_rsp.found    = 1'b1;
         fetch_rsp.is_long  = 1'b1;
         fetch_rsp.stage    = cpwe_pkg::STAGE_TAIL;
         fetch_rsp.run_left = tail_cnt - 16'd1;
      end
   end

endmodule

FILE: hdl/cassette_pulse_width_encoder.sv
// Cassette pulse width encoder top level: command decode, phase counters, result queue.
// Depends on cpwe_pkg, cpwe_pulse_fetch and assert_macros.svh.
//
//   port group | direction | handshake          | payload
//   req_       | in        | req_valid/req_stall | operation, value
//   rsp_       | out       | rsp_valid/rsp_stall | sample_valid, sample, busy_res,
//              |           |                     | accepted, ones_count
//   csr_       | in/out    | APB psel/penable    | four phase registers and polarity
//
// One item per cycle unless stalled; an item's result is registered in the next cycle.
// The phase counter and next-pulse finder settle a whole command step combinationally.
// A two-entry result queue (output register plus skid) sets req_stall; it is high while
// the skid entry is occupied, which only happens once rsp_stall holds the output register.
// Synchronous reset restores the CSRs, idles the command state and empties the queue.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module cassette_pulse_width_encoder (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [cpwe_pkg::OP_W-1:0]        req_operation,
   input  logic [cpwe_pkg::VALUE_W-1:0]     req_value,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_sample_valid,
   output logic [7:0]                       rsp_sample,
   output logic                             rsp_busy_res,
   output logic                             rsp_accepted,
   output logic [cpwe_pkg::ONES_W-1:0]      rsp_ones_count,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [cpwe_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [cpwe_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [cpwe_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready
);

   // configuration
   logic [cpwe_pkg::LEN_W-1:0] long_high_ff;
   logic [cpwe_pkg::LEN_W-1:0] long_low_ff;
   logic [cpwe_pkg::LEN_W-1:0] short_high_ff;
   logic [cpwe_pkg::LEN_W-1:0] short_low_ff;
   logic                       polarity_ff;
   logic                       csr_write;
   logic [2:0]                 csr_index;

   // command state
   cpwe_pkg::kind_type           kind_ff, kind_in;
   logic [cpwe_pkg::SEQ_LEN-1:0] seq_ff, seq_in;
   logic [cpwe_pkg::POS_W-1:0]   len_ff, len_in;
   logic [cpwe_pkg::POS_W-1:0]   pos_ff, pos_in;
   logic [1:0]                   stage_ff, stage_in;
   logic [cpwe_pkg::VALUE_W-1:0] run_left_ff, run_left_in;
   logic [cpwe_pkg::VALUE_W-1:0] mark_n_ff, mark_n_in;
   logic                         mark_ff, mark_in;
   logic                         long_ff, long_in;
   logic                         second_ff, second_in;
   logic [cpwe_pkg::LEN_W-1:0]   phase_left_ff, phase_left_in;
   logic [cpwe_pkg::COUNT_BITS-1:0] total_ff, total_in;

   // result queue
   logic              out_valid_ff, out_valid_in;
   logic              skid_valid_ff, skid_valid_in;
   cpwe_pkg::rsp_type out_data_ff, out_data_in;
   cpwe_pkg::rsp_type skid_data_ff, skid_data_in;
   cpwe_pkg::rsp_type new_rsp;

   logic                         push;
   logic                         pop;
   logic                         is_cmd;
   logic                         tick_go;
   logic                         cmd_go;
   logic                         need_fetch;
   logic                         long_ok;
   logic                         short_ok;
   logic [cpwe_pkg::LEN_W-1:0]   low_len;
   logic [cpwe_pkg::LEN_W-1:0]   fetch_high;
   logic [cpwe_pkg::LEN_W-1:0]   fetch_low;
   logic [cpwe_pkg::LEN_W-1:0]   left_dec;
   logic [cpwe_pkg::ONES_W-1:0]  ones;
   cpwe_pkg::kind_type           init_kind;
   cpwe_pkg::fetch_req_type      init_req;
   cpwe_pkg::fetch_req_type      cur_req;
   cpwe_pkg::fetch_req_type      fetch_req;
   cpwe_pkg::fetch_rsp_type      fetch_rsp;

   // --- configuration port ---
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[4:2];

   always_comb begin
      case (csr_index)
         cpwe_pkg::REG_LONG_HIGH:  csr_prdata = {24'd0, long_high_ff};
         cpwe_pkg::REG_LONG_LOW:   csr_prdata = {24'd0, long_low_ff};
         cpwe_pkg::REG_SHORT_HIGH: csr_prdata = {24'd0, short_high_ff};
         cpwe_pkg::REG_SHORT_LOW:  csr_prdata = {24'd0, short_low_ff};
         cpwe_pkg::REG_POLARITY:   csr_prdata = {31'd0, polarity_ff};
         default:                  csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         long_high_ff  <= cpwe_pkg::RESET_LONG_LEN;
         long_low_ff   <= cpwe_pkg::RESET_LONG_LEN;
         short_high_ff <= cpwe_pkg::RESET_SHORT_LEN;
         short_low_ff  <= cpwe_pkg::RESET_SHORT_LEN;
         polarity_ff   <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            cpwe_pkg::REG_LONG_HIGH:  long_high_ff  <= csr_pwdata[7:0];
            cpwe_pkg::REG_LONG_LOW:   long_low_ff   <= csr_pwdata[7:0];
            cpwe_pkg::REG_SHORT_HIGH: short_high_ff <= csr_pwdata[7:0];
            cpwe_pkg::REG_SHORT_LOW:  short_low_ff  <= csr_pwdata[7:0];
            cpwe_pkg::REG_POLARITY:   polarity_ff   <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   // --- item handshake ---
   assign req_stall = skid_valid_ff;
   assign push      = req_valid && !req_stall;
   assign pop       = out_valid_ff && !rsp_stall;

   assign is_cmd  = (req_operation == cpwe_pkg::OP_BYTE) || (req_operation == cpwe_pkg::OP_GAP) ||
                    (req_operation == cpwe_pkg::OP_MARK) || (req_operation == cpwe_pkg::OP_CSUM);
   assign tick_go = push && (req_operation == cpwe_pkg::OP_TICK) &&
                    (kind_ff != cpwe_pkg::KIND_IDLE);
   assign cmd_go  = push && is_cmd && (kind_ff == cpwe_pkg::KIND_IDLE);

   assign long_ok  = (long_high_ff != '0) || (long_low_ff != '0);
   assign short_ok = (short_high_ff != '0) || (short_low_ff != '0);

   // --- command load ---
   always_comb begin
      init_req          = '0;
      init_kind         = cpwe_pkg::KIND_RUN;
      init_req.run_left = req_value;
      init_req.mark_n   = req_value;
      init_req.stage    = cpwe_pkg::STAGE_SHORT;
      ones              = '0;
      for (int j = 0; j < 8; j++) begin
         ones = ones + cpwe_pkg::ONES_W'(req_value[j]);
      end
      case (req_operation)
         cpwe_pkg::OP_BYTE: begin
            init_kind       = cpwe_pkg::KIND_SEQ;
            init_req.is_seq = 1'b1;
            init_req.len    = cpwe_pkg::BYTE_PULSES;
            for (int j = 0; j < 8; j++) begin
               init_req.seq[j] = req_value[7-j];
            end
            init_req.seq[8] = 1'b1;
         end
         cpwe_pkg::OP_CSUM: begin
            init_kind       = cpwe_pkg::KIND_SEQ;
            init_req.is_seq = 1'b1;
            init_req.len    = cpwe_pkg::CSUM_PULSES;
            for (int j = 0; j < 8; j++) begin
               init_req.seq[j]   = req_value[15-j];
               init_req.seq[9+j] = req_value[7-j];
            end
            init_req.seq[8]  = 1'b1;
            init_req.seq[17] = 1'b1;
         end
         cpwe_pkg::OP_MARK: begin
            init_req.mark  = 1'b1;
            init_req.stage = cpwe_pkg::STAGE_LEAD;
         end
         default: ;
      endcase
   end

   always_comb begin
      cur_req.is_seq   = (kind_ff == cpwe_pkg::KIND_SEQ);
      cur_req.seq      = seq_ff;
      cur_req.len      = len_ff;
      cur_req.pos      = pos_ff;
      cur_req.stage    = stage_ff;
      cur_req.run_left = run_left_ff;
      cur_req.mark_n   = mark_n_ff;
      cur_req.mark     = mark_ff;
   end

   assign fetch_req = cmd_go ? init_req : cur_req;

   cpwe_pulse_fetch u_fetch (
      .fetch_req (fetch_req),
      .long_ok   (long_ok),
      .short_ok  (short_ok),
      .fetch_rsp (fetch_rsp)
   );

   // --- phase sequencing ---
   assign low_len    = long_ff ? long_low_ff : short_low_ff;
   assign fetch_high = fetch_rsp.is_long ? long_high_ff : short_high_ff;
   assign fetch_low  = fetch_rsp.is_long ? long_low_ff : short_low_ff;
   assign left_dec   = phase_left_ff - 8'd1;

   always_comb begin
      kind_in       = kind_ff;
      seq_in        = seq_ff;
      len_in        = len_ff;
      pos_in        = pos_ff;
      stage_in      = stage_ff;
      run_left_in   = run_left_ff;
      mark_n_in     = mark_n_ff;
      mark_in       = mark_ff;
      long_in       = long_ff;
      second_in     = second_ff;
      phase_left_in = phase_left_ff;
      total_in      = total_ff;
      need_fetch    = 1'b0;

      if (cmd_go) begin
         kind_in    = init_kind;
         seq_in     = init_req.seq;
         len_in     = init_req.len;
         mark_n_in  = init_req.mark_n;
         mark_in    = init_req.mark;
         need_fetch = 1'b1;
      end

      if (tick_go) begin
         total_in = total_ff + cpwe_pkg::COUNT_BITS'(1);
         if (left_dec != '0) begin
            phase_left_in = left_dec;
         end else if (!second_ff && (low_len != '0)) begin
            second_in     = 1'b1;
            phase_left_in = low_len;
         end else begin
            need_fetch = 1'b1;
         end
      end

      if (need_fetch) begin
         pos_in      = fetch_rsp.pos;
         stage_in    = fetch_rsp.stage;
         run_left_in = fetch_rsp.run_left;
         long_in     = fetch_rsp.is_long;
         if (!fetch_rsp.found) begin
            kind_in       = cpwe_pkg::KIND_IDLE;
            phase_left_in = '0;
         end else if (fetch_high != '0) begin
            second_in     = 1'b0;
            phase_left_in = fetch_high;
         end else begin
            second_in     = 1'b1;
            phase_left_in = fetch_low;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff       <= cpwe_pkg::KIND_IDLE;
         phase_left_ff <= '0;
         total_ff      <= '0;
      end else begin
         kind_ff       <= kind_in;
         phase_left_ff <= phase_left_in;
         total_ff      <= total_in;
      end
      seq_ff      <= seq_in;
      len_ff      <= len_in;
      pos_ff      <= pos_in;
      stage_ff    <= stage_in;
      run_left_ff <= run_left_in;
      mark_n_ff   <= mark_n_in;
      mark_ff     <= mark_in;
      long_ff     <= long_in;
      second_ff   <= second_in;
   end

   // --- result queue ---
   always_comb begin
      new_rsp.sample_valid = tick_go;
      new_rsp.sample       = '0;
      if (tick_go) begin
         new_rsp.sample = (second_ff ^ polarity_ff) ? cpwe_pkg::LEVEL_SECOND
                                                    : cpwe_pkg::LEVEL_FIRST;
      end
      new_rsp.busy_res   = (kind_in != cpwe_pkg::KIND_IDLE);
      new_rsp.accepted   = cmd_go;
      new_rsp.ones_count = (cmd_go && (req_operation == cpwe_pkg::OP_BYTE)) ? ones : '0;
   end

   always_comb begin
      out_valid_in  = out_valid_ff && !pop;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff && pop) begin
         out_valid_in  = 1'b1;
         out_data_in   = skid_data_ff;
         skid_valid_in = 1'b0;
      end
      if (push) begin
         if (!out_valid_ff || pop) begin
            out_valid_in = 1'b1;
            out_data_in  = new_rsp;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = new_rsp;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_sample_valid = out_data_ff.sample_valid;
   assign rsp_sample       = out_data_ff.sample;
   assign rsp_busy_res     = out_data_ff.busy_res;
   assign rsp_accepted     = out_data_ff.accepted;
   assign rsp_ones_count   = out_data_ff.ones_count;

   `CPWE_ASSERT_IMP(a_busy_has_samples, kind_ff != cpwe_pkg::KIND_IDLE, phase_left_ff != '0, "busy with empty phase")
   `CPWE_ASSERT_IMP(a_skid_behind_out, skid_valid_ff, out_valid_ff, "skid holds an item ahead of output")
   `CPWE_ASSERT_NXT(a_kind_moves_on_item, !push, $stable(kind_ff), "command state moved without an item")
   `CPWE_ASSERT_IMP(a_pos_in_range, kind_ff == cpwe_pkg::KIND_SEQ, pos_ff <= len_ff, "pulse pointer past end")

endmodule
